FILE: hw/rtl/pcc_pkg.sv
// pcc_pkg: shared types, widths and constants of the polar/cartesian converter.
// No dependencies; imported by every module under hw/rtl.
package pcc_pkg;

    // cordic run length, one cell per step
    localparam int ROTATION_STEPS = 24;
    localparam int IDXW = 5;

    // field widths
    localparam int DW = 24;
    localparam int AW = 16;

    // internal datapath: coordinates carry GUARD extra fraction bits
    localparam int GUARD = 32;
    localparam int XW = 58;
    localparam int ZW = 32;

    // inverse cordic gain, Q0.32
    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    // magnitude scaling: (x >> MAG_PRE_SHIFT) * INV_GAIN, rounded >> MAG_POST_SHIFT
    localparam int MAG_PRE_SHIFT = 24;
    localparam int MAG_POST_SHIFT = 40;
    localparam int MXW = XW - 1 - MAG_PRE_SHIFT;
    localparam int PW = MXW + 32;

    // action codes
    localparam logic [1:0] ACT_CART = 2'd0;
    localparam logic [1:0] ACT_POLAR = 2'd1;

    typedef enum logic [1:0] {
        MODE_VECT,
        MODE_ROT,
        MODE_CLEAR
    } pcc_mode_t;

    // word handed from stage to stage
    typedef struct packed {
        pcc_mode_t             mode;
        logic                  zero;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic [ZW-1:0]         z;
        logic [DW-1:0]         echo_a;
        logic [DW-1:0]         echo_b;
    } pcc_word_t;

    // arctangent of 2^-i, 2^32 per full turn
    function automatic logic [ZW-1:0] pcc_atan(input logic [IDXW-1:0] i);
        logic [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/pcc_prep.sv
// pcc_prep: input stage; decodes the form, folds the vector into the working
// half plane and applies the inverse gain for polar input. Uses pcc_pkg.
module pcc_prep
    import pcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    output logic                 ready_up,
    input  logic [1:0]           action,
    input  logic signed [DW-1:0] first_value,
    input  logic signed [DW-1:0] second_value,
    output logic                 valid_out,
    input  logic                 ready_down,
    output pcc_word_t            word_out
);

    logic                valid_reg;
    pcc_word_t           word_reg;
    pcc_word_t           word_next;
    logic signed [DW:0]  a_s;
    logic signed [DW:0]  b_s;
    logic signed [DW:0]  xv;
    logic signed [DW:0]  yv;
    logic [ZW-1:0]       zv;
    logic [DW-1:0]       m;
    logic signed [DW:0]  m_s;
    logic signed [DW:0]  ms;
    logic signed [32:0]  gain_s;
    logic signed [XW-1:0] prod;
    logic                flip;

    // quarter-turn fold for vectoring
    always_comb
    begin
        a_s = {first_value[DW-1], first_value};
        b_s = {second_value[DW-1], second_value};
        xv = a_s;
        yv = b_s;
        zv = '0;
        if (first_value[DW-1])
        begin
            if (!second_value[DW-1])
            begin
                xv = b_s;
                yv = -a_s;
                zv = 32'h40000000;
            end
            else
            begin
                xv = -b_s;
                yv = a_s;
                zv = 32'hC0000000;
            end
        end
    end

    // polar: clamp magnitude, fold angle, scale by inverse gain
    always_comb
    begin
        m = first_value[DW-1] ? '0 : first_value;
        m_s = {1'b0, m};
        flip = second_value[AW-1] ^ second_value[AW-2];
        ms = flip ? -m_s : m_s;
        gain_s = {1'b0, INV_GAIN};
        prod = ms * gain_s;
    end

    // form decode
    always_comb
    begin
        word_next = '0;
        unique case (action)
            ACT_CART:
            begin
                word_next.mode = MODE_VECT;
                word_next.zero = (first_value == '0) && (second_value == '0);
                word_next.x = XW'(xv) <<< GUARD;
                word_next.y = XW'(yv) <<< GUARD;
                word_next.z = zv;
                word_next.echo_a = first_value;
                word_next.echo_b = second_value;
            end
            ACT_POLAR:
            begin
                word_next.mode = MODE_ROT;
                word_next.x = prod;
                word_next.y = '0;
                word_next.z = {second_value[AW-1:0], {(ZW-AW){1'b0}}}
                              + (flip ? 32'h80000000 : 32'h0);
                word_next.echo_a = m;
                word_next.echo_b = second_value;
            end
            default:
            begin
                word_next.mode = MODE_CLEAR;
            end
        endcase
    end

    assign ready_up = !valid_reg || ready_down;
    assign valid_out = valid_reg;
    assign word_out = word_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hw/rtl/pcc_cell.sv
// pcc_cell: one cordic micro-rotation with its pipeline register.
// Step index arrives on a port tied to a constant. Uses pcc_pkg.
module pcc_cell
    import pcc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IDXW-1:0] step,
    input  logic            valid_in,
    output logic            ready_up,
    input  pcc_word_t       word_in,
    output logic            valid_out,
    input  logic            ready_down,
    output pcc_word_t       word_out
);

    logic                 valid_reg;
    pcc_word_t            word_reg;
    pcc_word_t            word_next;
    logic signed [XW-1:0] x_cur;
    logic signed [XW-1:0] y_cur;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [ZW-1:0]        angle;
    logic                 cw;

    // direction: vectoring drives y to zero, rotation drives z to zero
    always_comb
    begin
        x_cur = word_in.x;
        y_cur = word_in.y;
        xs = x_cur >>> step;
        ys = y_cur >>> step;
        angle = pcc_atan(step);
        unique case (word_in.mode)
            MODE_VECT: cw = !y_cur[XW-1];
            MODE_ROT:  cw = word_in.z[ZW-1];
            default:   cw = 1'b0;
        endcase
        word_next = word_in;
        if (word_in.mode != MODE_CLEAR)
        begin
            if (cw)
            begin
                word_next.x = x_cur + ys;
                word_next.y = y_cur - xs;
                word_next.z = word_in.z + angle;
            end
            else
            begin
                word_next.x = x_cur - ys;
                word_next.y = y_cur + xs;
                word_next.z = word_in.z - angle;
            end
        end
    end

    assign ready_up = !valid_reg || ready_down;
    assign valid_out = valid_reg;
    assign word_out = word_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: hw/rtl/pcc_post.sv
// pcc_post: gain correction of the magnitude, rounding, saturation and the
// output register. Two pipeline stages. Uses pcc_pkg.
module pcc_post
    import pcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    output logic                 ready_up,
    input  pcc_word_t            word_in,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic [DW-1:0]        magnitude_out,
    output logic signed [AW-1:0] angle_out,
    output logic                 form_out
);

    localparam int SHW = XW - GUARD;
    localparam int MFW = PW - MAG_POST_SHIFT + 1;
    localparam logic [PW:0] MAG_ROUND = (PW+1)'(1) << (MAG_POST_SHIFT - 1);
    localparam logic signed [XW-1:0] ROT_ROUND = XW'(1) <<< (GUARD - 1);
    localparam logic signed [SHW-1:0] SAT_HI = SHW'((2 ** (DW - 1)) - 1);
    localparam logic signed [SHW-1:0] SAT_LO = -SHW'(2 ** (DW - 1));
    localparam logic [ZW-1:0] ANG_ROUND = ZW'(1) << (ZW - AW - 1);

    function automatic logic signed [DW-1:0] sat_coord(input logic signed [SHW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DW-1:0];
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    logic                 a_valid_reg;
    pcc_word_t            a_word_reg;
    logic [PW-1:0]        a_prod_reg;
    logic                 a_ready;
    logic                 b_ready;
    logic [MXW-1:0]       mag_x;
    logic [PW-1:0]        prod_next;

    logic                 out_valid_reg;
    logic signed [DW-1:0] x_out_reg;
    logic signed [DW-1:0] y_out_reg;
    logic [DW-1:0]        mag_out_reg;
    logic signed [AW-1:0] ang_out_reg;
    logic                 form_out_reg;

    logic signed [DW-1:0] x_next;
    logic signed [DW-1:0] y_next;
    logic [DW-1:0]        mag_next;
    logic signed [AW-1:0] ang_next;
    logic                 form_next;
    logic [PW:0]          mag_sum;
    logic [MFW-1:0]       mag_full;
    logic signed [XW-1:0] rx_sum;
    logic signed [XW-1:0] ry_sum;
    logic [ZW-1:0]        z_sum;

    // stage a: clamp x and apply the inverse gain
    always_comb
    begin
        mag_x = word_in.x[XW-1] ? '0 : word_in.x[XW-2:MAG_PRE_SHIFT];
        prod_next = PW'(mag_x) * PW'(INV_GAIN);
    end

    assign b_ready = !out_valid_reg || result_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign ready_up = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && valid_in)
        begin
            a_word_reg <= word_in;
            a_prod_reg <= prod_next;
        end
    end

    // stage b: rounding, saturation and field selection
    always_comb
    begin
        mag_sum = {1'b0, a_prod_reg} + MAG_ROUND;
        mag_full = mag_sum[PW:MAG_POST_SHIFT];
        rx_sum = a_word_reg.x + ROT_ROUND;
        ry_sum = a_word_reg.y + ROT_ROUND;
        z_sum = a_word_reg.z + ANG_ROUND;
        x_next = '0;
        y_next = '0;
        mag_next = '0;
        ang_next = '0;
        form_next = 1'b0;
        unique case (a_word_reg.mode)
            MODE_VECT:
            begin
                x_next = a_word_reg.echo_a;
                y_next = a_word_reg.echo_b;
                if (!a_word_reg.zero)
                begin
                    if (mag_full > MFW'({DW{1'b1}}))
                    begin
                        mag_next = '1;
                    end
                    else
                    begin
                        mag_next = mag_full[DW-1:0];
                    end
                    ang_next = z_sum[ZW-1:ZW-AW];
                end
            end
            MODE_ROT:
            begin
                x_next = sat_coord(rx_sum[XW-1:GUARD]);
                y_next = sat_coord(ry_sum[XW-1:GUARD]);
                mag_next = a_word_reg.echo_a;
                ang_next = a_word_reg.echo_b[AW-1:0];
                form_next = 1'b1;
            end
            default:
            begin
                form_next = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            x_out_reg <= x_next;
            y_out_reg <= y_next;
            mag_out_reg <= mag_next;
            ang_out_reg <= ang_next;
            form_out_reg <= form_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;
    assign magnitude_out = mag_out_reg;
    assign angle_out = ang_out_reg;
    assign form_out = form_out_reg;

endmodule

FILE: hw/rtl/polar_cartesian_converter.sv
// polar_cartesian_converter: top level, input stage, chain of cordic cells
// and output stage. Uses pcc_pkg, pcc_prep, pcc_cell, pcc_post.
//
//   channel  handshake                    fields
//   -------  ---------------------------  ---------------------------------------
//   item     item_valid / item_ready      action, first_value, second_value
//   result   result_valid / result_ready  x_out, y_out, magnitude_out,
//                                         angle_out, form_out
//
// One word enters per clock while result_ready does not stall the chain. A word
// passes one input stage, one cell per cordic step, then the gain multiply stage
// and the output register. Every stage has its own valid bit and takes a new
// word whenever it is empty or its successor moves, so bubbles are squeezed
// out under stalls. Reset clears only the valid bits.
module polar_cartesian_converter
    import pcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           action,
    input  logic signed [DW-1:0] first_value,
    input  logic signed [DW-1:0] second_value,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic [DW-1:0]        magnitude_out,
    output logic signed [AW-1:0] angle_out,
    output logic                 form_out
);

    pcc_word_t chain_word  [0:ROTATION_STEPS];
    logic      chain_valid [0:ROTATION_STEPS];
    logic      chain_ready [0:ROTATION_STEPS];

    // input stage
    pcc_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (item_valid),
        .ready_up     (item_ready),
        .action       (action),
        .first_value  (first_value),
        .second_value (second_value),
        .valid_out    (chain_valid[0]),
        .ready_down   (chain_ready[0]),
        .word_out     (chain_word[0])
    );

    // cordic cells, one step each
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_cell
        pcc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (IDXW'(i)),
            .valid_in   (chain_valid[i]),
            .ready_up   (chain_ready[i]),
            .word_in    (chain_word[i]),
            .valid_out  (chain_valid[i+1]),
            .ready_down (chain_ready[i+1]),
            .word_out   (chain_word[i+1])
        );
    end

    // gain correction and output register
    pcc_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (chain_valid[ROTATION_STEPS]),
        .ready_up      (chain_ready[ROTATION_STEPS]),
        .word_in       (chain_word[ROTATION_STEPS]),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .x_out         (x_out),
        .y_out         (y_out),
        .magnitude_out (magnitude_out),
        .angle_out     (angle_out),
        .form_out      (form_out)
    );

endmodule

FILE: verif/tb_polar_cartesian_converter.sv
// tb_polar_cartesian_converter: self-checking bench for the cordic vector converter.
// Depends on pcc_pkg and polar_cartesian_converter; a directed table, then random words
// under several idle/stall patterns, each result checked against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_polar_cartesian_converter;
    import pcc_pkg::*;

    // action codes the package leaves unnamed
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam int        CORDIC_STEPS   = ROTATION_STEPS;
    localparam int        FRAC_GUARD     = 32;
    localparam longint    GAIN_INV_Q32   = 64'd2608131496;
    localparam longint    ROUND_HALF     = 64'sh80000000;
    localparam logic [31:0] QUARTER_TURN = 32'h40000000;
    localparam logic [31:0] HALF_TURN    = 32'h80000000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC0000000;
    localparam longint    FIELD_MAX      = 64'sd8388607;
    localparam longint    FIELD_MIN      = -64'sd8388608;
    localparam int        PIPE_LATENCY   = ROTATION_STEPS + 3;
    localparam int        HOLD_CYCLES    = 200;
    localparam int        PHASE_WORDS    = 350;
    localparam int        MAX_PRINTS     = 50;

    // arctangent of 2^-i, one full turn = 2^32
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] mag;
        logic [AW-1:0] ang;
        logic          form;
    } vec_result_t;

    typedef struct packed {
        logic [1:0]    act;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic          typed;
        vec_result_t   want;
    } stim_row_t;

    // directed words; typed results only where they are obvious
    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // invalid forms clear everything
        '{ACT_CLEAR,    24'h7FFFFF, 24'h800000, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h0, 1'b0}},
        '{ACT_RESERVED, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h0, 1'b0}},
        // zero vector
        '{ACT_CART,     24'h000000, 24'h000000, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h0, 1'b0}},
        // zero magnitude, angle echoed
        '{ACT_POLAR,    24'h000000, 24'h001234, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h1234, 1'b1}},
        // negative magnitude acts as zero
        '{ACT_POLAR,    24'hFFFFFB, 24'hFF8000, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h8000, 1'b1}},
        '{ACT_POLAR,    24'h800000, 24'h7F4000, 1'b1, '{24'h0, 24'h0, 24'h0, 16'h4000, 1'b1}},
        // cartesian corners and axes
        '{ACT_CART,     24'h7FFFFF, 24'h7FFFFF, 1'b0, '0},
        '{ACT_CART,     24'h800000, 24'h800000, 1'b0, '0},
        '{ACT_CART,     24'h800000, 24'h7FFFFF, 1'b0, '0},
        '{ACT_CART,     24'h7FFFFF, 24'h800000, 1'b0, '0},
        '{ACT_CART,     24'h000100, 24'h000000, 1'b0, '0},
        '{ACT_CART,     24'h000000, 24'h000100, 1'b0, '0},
        '{ACT_CART,     24'hFFFF00, 24'h000000, 1'b0, '0},
        '{ACT_CART,     24'h000000, 24'hFFFF00, 1'b0, '0},
        '{ACT_CART,     24'hFFFFFF, 24'h000000, 1'b0, '0},
        '{ACT_CART,     24'h000001, 24'hFFFFFF, 1'b0, '0},
        '{ACT_CART,     24'h000000, 24'h800000, 1'b0, '0},
        // polar around the circle, mostly at full magnitude
        '{ACT_POLAR,    24'h7FFFFF, 24'h000000, 1'b0, '0},
        '{ACT_POLAR,    24'h7FFFFF, 24'h004000, 1'b0, '0},
        '{ACT_POLAR,    24'h7FFFFF, 24'h008000, 1'b0, '0},
        '{ACT_POLAR,    24'h7FFFFF, 24'h00C000, 1'b0, '0},
        '{ACT_POLAR,    24'h7FFFFF, 24'h007FFF, 1'b0, '0},
        '{ACT_POLAR,    24'h7FFFFF, 24'h002000, 1'b0, '0},
        '{ACT_POLAR,    24'h000100, 24'hFFBFFF, 1'b0, '0},
        '{ACT_POLAR,    24'h000001, 24'hFFFFFF, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic [1:0]           action;
    logic signed [DW-1:0] first_value;
    logic signed [DW-1:0] second_value;
    logic                 result_valid;
    logic                 result_ready;
    logic signed [DW-1:0] x_out;
    logic signed [DW-1:0] y_out;
    logic [DW-1:0]        magnitude_out;
    logic signed [AW-1:0] angle_out;
    logic                 form_out;

    vec_result_t pending_results[$];
    int          error_count = 0;
    int          result_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req_cnt = 0;

    polar_cartesian_converter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .first_value   (first_value),
        .second_value  (second_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .x_out         (x_out),
        .y_out         (y_out),
        .magnitude_out (magnitude_out),
        .angle_out     (angle_out),
        .form_out      (form_out)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // clamp to the 24-bit signed range
    function automatic logic [DW-1:0] clamp24(longint v);
        if (v > FIELD_MAX)
            return FIELD_MAX[DW-1:0];
        if (v < FIELD_MIN)
            return FIELD_MIN[DW-1:0];
        return v[DW-1:0];
    endfunction

    // expected result of one input word
    function automatic vec_result_t convert_vector(logic [1:0] act, logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
        vec_result_t r;
        longint      x;
        longint      y;
        longint      t;
        longint      xs;
        longint      ys;
        longint      m;
        logic [31:0] z;
        logic [31:0] zr;
        logic [63:0] prod;
        logic [63:0] mq;
        r = '0;
        if (act == ACT_CART)
        begin
            r.x = a;
            r.y = b;
            if (a != 0 || b != 0)
            begin
                x = a;
                y = b;
                z = '0;
                // fold left half plane into the right by a quarter turn
                if (x < 0)
                begin
                    if (y >= 0)
                    begin
                        t = x; x = y; y = -t; z = QUARTER_TURN;
                    end
                    else
                    begin
                        t = x; x = -y; y = t; z = THREE_QUARTER_TURN;
                    end
                end
                x = x <<< FRAC_GUARD;
                y = y <<< FRAC_GUARD;
                // vectoring: drive y to zero
                for (int i = 0; i < CORDIC_STEPS; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y < 0)
                    begin
                        x -= ys; y += xs; z -= ATAN_TURN[i];
                    end
                    else
                    begin
                        x += ys; y -= xs; z += ATAN_TURN[i];
                    end
                end
                if (x < 0)
                    x = 0;
                // remove cordic gain, round to nearest
                prod = x >>> 24;
                prod = prod * GAIN_INV_Q32;
                mq = (prod + (64'd1 << 39)) >> 40;
                r.mag = (mq > 64'hFFFFFF) ? 24'hFFFFFF : mq[DW-1:0];
                zr = z + 32'h8000;
                r.ang = zr[31:16];
            end
        end
        else if (act == ACT_POLAR)
        begin
            m = (a < 0) ? 0 : a;
            z = {b[15:0], 16'h0000};
            x = m * GAIN_INV_Q32;
            y = 0;
            // angles in the back half start from the negated vector
            if (z[31:30] == 2'b01 || z[31:30] == 2'b10)
            begin
                x = -x;
                z += HALF_TURN;
            end
            // rotation: drive z to zero
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z[31])
                begin
                    x += ys; y -= xs; z += ATAN_TURN[i];
                end
                else
                begin
                    x -= ys; y += xs; z -= ATAN_TURN[i];
                end
            end
            r.x = clamp24((x + ROUND_HALF) >>> FRAC_GUARD);
            r.y = clamp24((y + ROUND_HALF) >>> FRAC_GUARD);
            r.mag = m[DW-1:0];
            r.ang = b[AW-1:0];
            r.form = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DW-1:0] got, logic [DW-1:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch on result word %0d, %s: got %h, expected %h",
                     result_count, field, got, want);
        error_count++;
    endtask

    // offer one word, hold it until taken, then log its expected result
    task automatic drive_word(logic [1:0] act, logic [DW-1:0] a, logic [DW-1:0] b,
                              logic typed, vec_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        action       <= act;
        first_value  <= a;
        second_value <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_results.push_back(typed ? want : convert_vector(act, a, b));
    endtask

    // mostly small or full-range values, with a few field extremes
    function automatic logic [DW-1:0] pick_value();
        logic [DW-1:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    3: v = 24'h000001;
                    default: v = 24'hFFFFFF;
                endcase
            end
            1, 2, 3:
            begin
                v = 24'($urandom_range(2047));
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = 24'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_random_word();
        logic [1:0]    act;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8:          act = ACT_CART;
            9, 10, 11, 12, 13, 14, 15, 16, 17:  act = ACT_POLAR;
            18:                                 act = ACT_CLEAR;
            default:                            act = ACT_RESERVED;
        endcase
        a = pick_value();
        b = pick_value();
        // polar magnitude is mostly non-negative
        if (act == ACT_POLAR && $urandom_range(9) != 0)
            a[DW-1] = 1'b0;
        drive_word(act, a, b, 1'b0, '0);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_ack_cnt;
        hold_left = 0;
        hold_ack_cnt = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ack_cnt != hold_req_cnt)
            begin
                hold_ack_cnt = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin
        vec_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word, x", x_out, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (x_out !== want.x)
                    report_mismatch("x", x_out, want.x);
                if (y_out !== want.y)
                    report_mismatch("y", y_out, want.y);
                if (magnitude_out !== want.mag)
                    report_mismatch("magnitude", magnitude_out, want.mag);
                if (angle_out !== want.ang)
                    report_mismatch("angle", 24'(angle_out), 24'(want.ang));
                if (form_out !== want.form)
                    report_mismatch("form", 24'(form_out), 24'(want.form));
            end
            result_count++;
        end
    end

    // stimulus
    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        action       <= ACT_CART;
        first_value  <= '0;
        second_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int i = 0; i < DIRECTED_ROWS; i++)
            drive_word(DIRECTED[i].act, DIRECTED[i].a, DIRECTED[i].b,
                       DIRECTED[i].typed, DIRECTED[i].want);

        // random phases with different idle patterns
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default:
                begin
                    // long hold-off while the sender keeps offering
                    send_idle_pct = 0;
                    recv_stall_pct = 14;
                    hold_req_cnt++;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word();
        end
        item_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 13) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
